FILE: rtl/pitched_voice_mixer_defines.svh
// ---------------------------------------------------------------------------
// pitched_voice_mixer_defines: assertion macros
// Shared concurrent assertion forms for the mixer checkers.
// ---------------------------------------------------------------------------
`ifndef PITCHED_VOICE_MIXER_DEFINES_SVH
`define PITCHED_VOICE_MIXER_DEFINES_SVH

// same-cycle implication
`define PVM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pvm assertion failed");

// next-cycle implication
`define PVM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pvm assertion failed");

`endif

FILE: rtl/pvm_pkg.sv
// ---------------------------------------------------------------------------
// pvm_pkg: pitched voice mixer shared types
// Item kinds, sequencer states and the voice table entry layout.
// ---------------------------------------------------------------------------
`default_nettype none

package pvm_pkg;

   localparam logic [1:0] KIND_FRAME = 2'd0;
   localparam logic [1:0] KIND_START = 2'd1;
   localparam logic [1:0] KIND_STOP  = 2'd2;
   localparam logic [1:0] KIND_LOAD  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_LOAD,
      ST_F_RD,
      ST_F_LAT,
      ST_F_NXT,
      ST_F_RDL,
      ST_F_RDR,
      ST_F_UPD,
      ST_P_RD,
      ST_P_CHK,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [5:0]  source;
      logic [15:0] base;
      logic [16:0] length;
      logic        stereo;
      logic [19:0] step;
      logic [32:0] position;
      logic        loop;
      logic        playing;
   } voice_entry_type;

endpackage

`default_nettype wire

FILE: rtl/pvm_chan_if.sv
// ---------------------------------------------------------------------------
// pvm_chan_if: mixer request and response channels
// Valid/ready channels carrying request and response beats.
// ---------------------------------------------------------------------------
`default_nettype none

interface pvm_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [15:0]        address;
   logic signed [15:0] sample_value;
   logic [16:0]        length;
   logic               stereo;
   logic [19:0]        pitch_step;
   logic               repeat_req;
   logic [5:0]         source_id;

   modport source (output valid, kind, address, sample_value, length, stereo,
                   pitch_step, repeat_req, source_id, input ready);
   modport sink   (input valid, kind, address, sample_value, length, stereo,
                   pitch_step, repeat_req, source_id, output ready);
endinterface

interface pvm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] mix_left;
   logic signed [15:0] mix_right;
   logic               accepted;
   logic [5:0]         active_voices;

   modport source (output valid, mix_left, mix_right, accepted, active_voices,
                   input ready);
   modport sink   (input valid, mix_left, mix_right, accepted, active_voices,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/pvm_ram.sv
// ---------------------------------------------------------------------------
// pvm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module pvm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output      logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/pitched_voice_mixer.sv
// Start and load write the voice table or sample store; stop scans voices until a source
// matches and clears its playing flag; frame reads each voice, skips stopped ones, reads
// left then right sample and writes kept voices back. One beat at a time; req ready only
// while idle. The frame loop is bound by the voice table ports and the single store read
// port. Reset: synchronous, clears the sequencer and the voice count; store and table
// contents undefined until written. The user keeps SAMPLE_WORDS a power of two, unchecked.
// ---------------------------------------------------------------------------
// pitched_voice_mixer: wavetable voice mixer
// Sample store plus voice table, walked voice by voice under a sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module pitched_voice_mixer #(
   parameter int MAX_VOICES   = 32,
   parameter int SAMPLE_WORDS = 65536
) (
   input wire logic   clock,
   input wire logic   reset,
   pvm_req_if.sink    req_bus,
   pvm_rsp_if.source  rsp_bus
);

   localparam int AW = $clog2(SAMPLE_WORDS);
   localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
   localparam int CW = $clog2(MAX_VOICES + 1);
   localparam int EW = $bits(pvm_pkg::voice_entry_type);

   pvm_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] kept_ff, kept_in;

   logic [15:0] addr_ff;
   logic [15:0] val_ff;
   logic [16:0] len_ff;
   logic        st_ff;
   logic [19:0] step_ff;
   logic        rep_ff;
   logic [5:0]  src_ff;

   pvm_pkg::voice_entry_type ent_ff, ent_in;
   logic [16:0] nxt_ff, nxt_in;
   logic [33:0] tgt_ff, tgt_in;
   logic [15:0] mixl_ff, mixl_in, mixr_ff, mixr_in;
   logic        acc_ff, acc_in;

   logic          v_we;
   logic [VW-1:0] v_waddr, v_raddr;
   pvm_pkg::voice_entry_type v_wdata, v_rdata;
   logic [EW-1:0] v_rbits;

   logic          s_we;
   logic [AW-1:0] s_waddr, s_raddr;
   logic [15:0]   s_rdata;

   logic [16:0] ix;
   logic [17:0] ix_ch;
   logic [17:0] addr_l;
   logic [34:0] end_lhs;
   logic        at_end;

   assign v_rdata = pvm_pkg::voice_entry_type'(v_rbits);

   pvm_ram #(.WIDTH(EW), .DEPTH(MAX_VOICES)) u_voice_ram (
      .clock   (clock),
      .wr_en   (v_we),
      .wr_addr (v_waddr),
      .wr_data (v_wdata),
      .rd_addr (v_raddr),
      .rd_data (v_rbits)
   );

   pvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_store_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (val_ff),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign req_bus.ready         = (state_ff == pvm_pkg::ST_IDLE);
   assign rsp_bus.valid         = (state_ff == pvm_pkg::ST_RESP);
   assign rsp_bus.mix_left      = mixl_ff;
   assign rsp_bus.mix_right     = mixr_ff;
   assign rsp_bus.accepted      = acc_ff;
   assign rsp_bus.active_voices = 6'(count_ff);

   assign ix      = {ent_ff.position[32:17], ent_ff.position[16] & ~ent_ff.stereo};
   assign ix_ch   = {1'b0, ix} + (ent_ff.stereo ? 18'd2 : 18'd1);
   assign addr_l  = {2'b00, ent_ff.base} + {1'b0, nxt_ff};
   assign end_lhs = {1'b0, tgt_ff} + (ent_ff.stereo ? 35'h20000 : 35'h10000);
   assign at_end  = end_lhs >= {2'b00, ent_ff.length, 16'h0000};

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      kept_in  = kept_ff;
      ent_in   = ent_ff;
      nxt_in   = nxt_ff;
      tgt_in   = tgt_ff;
      mixl_in  = mixl_ff;
      mixr_in  = mixr_ff;
      acc_in   = acc_ff;
      v_we     = 1'b0;
      v_waddr  = idx_ff[VW-1:0];
      v_wdata  = ent_ff;
      v_raddr  = idx_ff[VW-1:0];
      s_we     = 1'b0;
      s_waddr  = AW'(addr_ff);
      s_raddr  = AW'(addr_l);

      unique case (state_ff)
         pvm_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               mixl_in = '0;
               mixr_in = '0;
               acc_in  = 1'b1;
               idx_in  = '0;
               kept_in = '0;
               unique case (req_bus.kind)
                  pvm_pkg::KIND_FRAME: state_in = pvm_pkg::ST_F_RD;
                  pvm_pkg::KIND_START: state_in = pvm_pkg::ST_START;
                  pvm_pkg::KIND_STOP:  state_in = pvm_pkg::ST_P_RD;
                  pvm_pkg::KIND_LOAD:  state_in = pvm_pkg::ST_LOAD;
                  default:             state_in = pvm_pkg::ST_LOAD;
               endcase
            end
         end
         pvm_pkg::ST_START: begin
            if (count_ff < CW'(MAX_VOICES)) begin
               v_we             = 1'b1;
               v_waddr          = count_ff[VW-1:0];
               v_wdata.source   = src_ff;
               v_wdata.base     = addr_ff;
               v_wdata.length   = (len_ff < 17'd2) ? 17'd2 : len_ff;
               v_wdata.stereo   = st_ff;
               v_wdata.step     = step_ff;
               v_wdata.position = '0;
               v_wdata.loop     = rep_ff;
               v_wdata.playing  = 1'b1;
               count_in         = count_ff + 1'b1;
            end else begin
               acc_in = 1'b0;
            end
            state_in = pvm_pkg::ST_RESP;
         end
         pvm_pkg::ST_LOAD: begin
            s_we     = 1'b1;
            state_in = pvm_pkg::ST_RESP;
         end
         pvm_pkg::ST_F_RD: begin
            if (idx_ff == count_ff) begin
               count_in = kept_ff;
               state_in = pvm_pkg::ST_RESP;
            end else begin
               state_in = pvm_pkg::ST_F_LAT;
            end
         end
         pvm_pkg::ST_F_LAT: begin
            ent_in = v_rdata;
            if (v_rdata.playing) begin
               state_in = pvm_pkg::ST_F_NXT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = pvm_pkg::ST_F_RD;
            end
         end
         pvm_pkg::ST_F_NXT: begin
            nxt_in = (ix_ch >= {1'b0, ent_ff.length}) ?
                     17'(ix_ch - {1'b0, ent_ff.length}) : ix_ch[16:0];
            tgt_in = {1'b0, ent_ff.position} +
                     (ent_ff.stereo ? {13'd0, ent_ff.step, 1'b0} : {14'd0, ent_ff.step});
            state_in = pvm_pkg::ST_F_RDL;
         end
         pvm_pkg::ST_F_RDL: begin
            state_in = pvm_pkg::ST_F_RDR;
         end
         pvm_pkg::ST_F_RDR: begin
            s_raddr = AW'(addr_l + 18'd1);
            mixl_in = mixl_ff + s_rdata;
            if (!ent_ff.stereo) begin
               mixr_in = mixr_ff + s_rdata;
            end
            state_in = pvm_pkg::ST_F_UPD;
         end
         pvm_pkg::ST_F_UPD: begin
            if (ent_ff.stereo) begin
               mixr_in = mixr_ff + s_rdata;
            end
            v_wdata.position = at_end ? 33'd0 : tgt_ff[32:0];
            v_waddr          = kept_ff[VW-1:0];
            if (!at_end || ent_ff.loop) begin
               v_we    = 1'b1;
               kept_in = kept_ff + 1'b1;
            end
            idx_in   = idx_ff + 1'b1;
            state_in = pvm_pkg::ST_F_RD;
         end
         pvm_pkg::ST_P_RD: begin
            state_in = (idx_ff == count_ff) ? pvm_pkg::ST_RESP : pvm_pkg::ST_P_CHK;
         end
         pvm_pkg::ST_P_CHK: begin
            if (v_rdata.source == src_ff) begin
               v_we            = 1'b1;
               v_wdata         = v_rdata;
               v_wdata.playing = 1'b0;
               state_in        = pvm_pkg::ST_RESP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = pvm_pkg::ST_P_RD;
            end
         end
         pvm_pkg::ST_RESP: begin
            if (rsp_bus.ready) begin
               state_in = pvm_pkg::ST_IDLE;
            end
         end
         default: state_in = pvm_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pvm_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      kept_ff <= kept_in;
      ent_ff  <= ent_in;
      nxt_ff  <= nxt_in;
      tgt_ff  <= tgt_in;
      mixl_ff <= mixl_in;
      mixr_ff <= mixr_in;
      acc_ff  <= acc_in;
      if (req_bus.valid && req_bus.ready) begin
         addr_ff <= req_bus.address;
         val_ff  <= req_bus.sample_value;
         len_ff  <= req_bus.length;
         st_ff   <= req_bus.stereo;
         step_ff <= req_bus.pitch_step;
         rep_ff  <= req_bus.repeat_req;
         src_ff  <= req_bus.source_id;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pvm_checker.sv
// ---------------------------------------------------------------------------
// pvm_checker: port-level checks for the voice mixer
// Watches the request and response channels of the top level.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pitched_voice_mixer_defines.svh"

module pvm_checker #(
   parameter int MAX_VOICES = 32
) (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_accepted,
   input wire logic [5:0] rsp_active
);

   `PVM_ASSERT_IMPLY(a_one_in_flight, clock, reset, rsp_valid, !req_ready)
   `PVM_ASSERT_IMPLY(a_count_bound, clock, reset, rsp_valid, rsp_active <= 6'(MAX_VOICES))
   `PVM_ASSERT_IMPLY(a_refuse_full, clock, reset, rsp_valid && !rsp_accepted,
      rsp_active == 6'(MAX_VOICES))
   `PVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

endmodule

bind pitched_voice_mixer pvm_checker #(.MAX_VOICES(MAX_VOICES)) u_pvm_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_accepted (rsp_bus.accepted),
   .rsp_active   (rsp_bus.active_voices)
);

`default_nettype wire
